// ----- src/kmp_pkg.sv -----
`default_nettype none
// ============================================================================
// kmp_pkg: shared types and constants for the KMP stream matcher
// Register indexes, result field limits, result record and pattern byte pick.
// ============================================================================
package kmp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    localparam int IDX_W = 20;
    localparam int CNT_W = 21;
    localparam logic [IDX_W-1:0] IDX_MAX = 20'hFFFFF;
    localparam int CNT_MAX = 21'h1FFFFF;

    typedef struct packed {
        logic             match_here;
        logic [IDX_W-1:0] match_start;
        logic [CNT_W-1:0] match_count;
        logic             first_found;
        logic [IDX_W-1:0] first_start;
        logic             end_of_text;
    } result_t;

    // byte k of the 16-byte pattern, byte 0 in bits 7..0 of the low word
    function automatic logic [7:0] pat_byte(input logic [63:0] lo,
                                            input logic [63:0] hi,
                                            input logic [3:0]  idx);
        logic [5:0] sh;
        sh = {idx[2:0], 3'b000};
        return idx[3] ? hi[sh +: 8] : lo[sh +: 8];
    endfunction

endpackage
`default_nettype wire

// ----- src/kmp_if.sv -----
`default_nettype none
// ============================================================================
// kmp_if: request channels of the KMP stream matcher
// Text byte channel and result channel, valid/ready handshake.
// ============================================================================
interface kmp_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface kmp_result_if;
    logic        valid;
    logic        ready;
    logic        match_here;
    logic [19:0] match_start;
    logic [20:0] match_count;
    logic        first_found;
    logic [19:0] first_start;
    logic        end_of_text;

    modport source (output valid, output match_here, output match_start,
                    output match_count, output first_found, output first_start,
                    output end_of_text, input ready);
    modport sink   (input valid, input match_here, input match_start,
                    input match_count, input first_found, input first_start,
                    input end_of_text, output ready);
endinterface
`default_nettype wire

// ----- src/kmp_link_table.sv -----
`default_nettype none
// ============================================================================
// kmp_link_table: failure-link storage
// One write port, one read port; contents undefined until built.
// ============================================================================
module kmp_link_table #(
    parameter int DEPTH = 17,
    parameter int AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [AW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [AW-1:0] rdata
);

    logic [AW-1:0] links_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            links_reg[waddr] <= wdata;
        end
    end

    assign rdata = links_reg[raddr];

endmodule
`default_nettype wire

// ----- src/kmp_match_core.sv -----
`default_nettype none
// ============================================================================
// kmp_match_core: sequencer around one shared byte comparator
// Builds failure links, then walks them for each text byte.
// ============================================================================
module kmp_match_core #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_TEXT    = 1048576
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    kmp_text_if.sink                text_in,
    input  wire logic [63:0]        pattern_low,
    input  wire logic [63:0]        pattern_high,
    input  wire logic [4:0]         pattern_len,
    input  wire logic               cfg_clear,
    input  wire logic               out_free,
    output logic                    res_load,
    output kmp_pkg::result_t        res
);
    import kmp_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int BW = $clog2(MAX_TEXT + 1);
    localparam logic [BW-1:0] POS_MAX  = BW'(MAX_TEXT - 1);
    localparam logic [BW-1:0] TEXT_LIM = BW'(MAX_TEXT);
    localparam int CNT_LIM = (MAX_TEXT < CNT_MAX) ? MAX_TEXT : CNT_MAX;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_BUILD = 3'b010,
        ST_WALK  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic            links_ready_reg, links_ready_next;
    logic [LW-1:0]   matched_reg, matched_next;
    logic [BW-1:0]   byte_index_reg, byte_index_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic            first_seen_reg, first_seen_next;
    logic [IDX_W-1:0] first_pos_reg, first_pos_next;
    logic [LW-1:0]   i_reg, i_next;
    logic [LW-1:0]   k_reg, k_next;
    logic [LW-1:0]   j_reg, j_next;
    logic [7:0]      char_reg;
    logic            last_reg;

    logic [LW-1:0]   n_len;
    logic [LW-1:0]   j_start;
    logic [LW-1:0]   b_idx;
    logic [7:0]      op_a;
    logic [7:0]      op_b;
    logic            eq;
    logic            follow;
    logic [LW-1:0]   j_ext;
    logic            hit;
    logic [BW-1:0]   pos;
    logic [BW-1:0]   start_full;
    logic [31:0]     start_w;
    logic [IDX_W-1:0] start_sat;
    logic            accept;

    logic            lt_we;
    logic [LW-1:0]   lt_waddr;
    logic [LW-1:0]   lt_wdata;
    logic [LW-1:0]   lt_raddr;
    logic [LW-1:0]   lt_rdata;

    kmp_link_table #(
        .DEPTH (MAX_PATTERN + 1),
        .AW    (LW)
    ) u_links (
        .clk   (clk),
        .we    (lt_we),
        .waddr (lt_waddr),
        .wdata (lt_wdata),
        .raddr (lt_raddr),
        .rdata (lt_rdata)
    );

    // clamp configured length into 1..MAX_PATTERN
    always_comb
    begin
        if (pattern_len == 5'd0)
        begin
            n_len = LW'(1);
        end
        else if (32'(pattern_len) > MAX_PATTERN)
        begin
            n_len = LW'(MAX_PATTERN);
        end
        else
        begin
            n_len = LW'(pattern_len);
        end
    end

    assign j_start = (matched_reg >= n_len) ? '0 : matched_reg;
    assign text_in.ready = (state_reg == ST_IDLE);
    assign accept = text_in.valid && text_in.ready;

    // shared comparator: pattern vs pattern while building, text vs pattern while walking
    assign b_idx  = (state_reg == ST_BUILD) ? k_reg : j_reg;
    assign op_b   = pat_byte(pattern_low, pattern_high, 4'(b_idx));
    assign op_a   = (state_reg == ST_BUILD) ? pat_byte(pattern_low, pattern_high, 4'(i_reg))
                                            : char_reg;
    assign eq     = (op_a == op_b);
    assign follow = !eq && (b_idx != '0);

    assign lt_raddr = (state_reg == ST_BUILD || follow) ? b_idx : n_len;

    assign j_ext = j_reg + LW'(eq);
    assign hit   = (j_ext == n_len);

    assign pos        = (byte_index_reg > POS_MAX) ? POS_MAX : byte_index_reg;
    assign start_full = pos + BW'(1) - BW'(n_len);
    assign start_w    = 32'(start_full);
    assign start_sat  = (start_w > 32'(IDX_MAX)) ? IDX_MAX : start_w[IDX_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        links_ready_next = links_ready_reg;
        matched_next     = matched_reg;
        byte_index_next  = byte_index_reg;
        count_next       = count_reg;
        first_seen_next  = first_seen_reg;
        first_pos_next   = first_pos_reg;
        i_next           = i_reg;
        k_next           = k_reg;
        j_next           = j_reg;
        lt_we            = 1'b0;
        lt_waddr         = i_reg + LW'(1);
        lt_wdata         = k_reg + LW'(eq);
        res_load         = 1'b0;
        res              = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    j_next = j_start;
                    if (!links_ready_reg)
                    begin
                        lt_we      = 1'b1;
                        lt_waddr   = LW'(1);
                        lt_wdata   = '0;
                        i_next     = LW'(1);
                        k_next     = '0;
                        state_next = ST_BUILD;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_BUILD:
            begin
                if (i_reg == n_len)
                begin
                    links_ready_next = 1'b1;
                    j_next           = j_start;
                    state_next       = ST_WALK;
                end
                else if (follow)
                begin
                    k_next = lt_rdata;
                end
                else
                begin
                    lt_we  = 1'b1;
                    k_next = k_reg + LW'(eq);
                    i_next = i_reg + LW'(1);
                end
            end
            ST_WALK:
            begin
                if (follow)
                begin
                    j_next = lt_rdata;
                end
                else if (out_free)
                begin
                    res_load = 1'b1;
                    if (hit)
                    begin
                        matched_next = lt_rdata;
                        if (count_reg < CNT_W'(CNT_LIM))
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        if (!first_seen_reg)
                        begin
                            first_seen_next = 1'b1;
                            first_pos_next  = start_sat;
                        end
                    end
                    else
                    begin
                        matched_next = j_ext;
                    end
                    if (byte_index_reg < TEXT_LIM)
                    begin
                        byte_index_next = byte_index_reg + BW'(1);
                    end

                    res.match_here  = hit;
                    res.match_start = hit ? start_sat : '0;
                    res.match_count = count_next;
                    res.first_found = first_seen_next;
                    res.first_start = first_seen_next ? first_pos_next : '0;
                    res.end_of_text = last_reg;

                    // last byte closes the text
                    if (last_reg)
                    begin
                        matched_next    = '0;
                        byte_index_next = '0;
                        count_next      = '0;
                        first_seen_next = 1'b0;
                        first_pos_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_clear)
        begin
            links_ready_next = 1'b0;
            matched_next     = '0;
            byte_index_next  = '0;
            count_next       = '0;
            first_seen_next  = 1'b0;
            first_pos_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            links_ready_reg <= 1'b0;
            matched_reg     <= '0;
            byte_index_reg  <= '0;
            count_reg       <= '0;
            first_seen_reg  <= 1'b0;
            first_pos_reg   <= '0;
            i_reg           <= '0;
            k_reg           <= '0;
            j_reg           <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            links_ready_reg <= links_ready_next;
            matched_reg     <= matched_next;
            byte_index_reg  <= byte_index_next;
            count_reg       <= count_next;
            first_seen_reg  <= first_seen_next;
            first_pos_reg   <= first_pos_next;
            i_reg           <= i_next;
            k_reg           <= k_next;
            j_reg           <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= text_in.text_byte;
            last_reg <= text_in.last_byte;
        end
    end

endmodule
`default_nettype wire

// ----- src/kmp_stream_matcher.sv -----
`default_nettype none
// ============================================================================
// kmp_stream_matcher: Knuth-Morris-Pratt byte stream matcher
// Configuration registers, matching core and result output register.
// ============================================================================
// Searches a byte stream for a pattern of 1 to MAX_PATTERN bytes held in the
// configuration registers and returns one result per text byte: match-end
// flag with start index, running count of overlapping matches, and the first
// match start. Each text request has an accept step, a hop for each failure
// link followed for that byte (amortized under one per byte) and a finishing
// step, all on the single shared byte comparator and the single link-table
// read port. The first byte after reset or after a write to a mapped register
// also pays for building the link table first. The finishing step waits while
// the result register is full and not being drained. The result register
// lets a new text byte be accepted while the previous result waits. A byte
// with last_byte set ends the text: its result carries the final counts and
// the matching state is cleared afterwards. Write configuration only while
// idle; any write to a mapped register restarts the text in progress.
// ============================================================================
module kmp_stream_matcher #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_TEXT    = 1048576
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    kmp_text_if.sink                         text_in,
    kmp_result_if.source                     result_out,
    input  wire logic                        cfg_we,
    input  wire logic [kmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kmp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kmp_pkg::*;

    // configuration registers
    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [4:0]  pattern_len_reg;
    logic        cfg_clear;

    // result output register
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg;
    logic        out_free;
    logic        res_load;
    result_t     res;

    // a write to a known register restarts matching and forces a link rebuild
    assign cfg_clear = cfg_we && (cfg_index == REG_PATTERN_LOW ||
                                  cfg_index == REG_PATTERN_HIGH ||
                                  cfg_index == REG_PATTERN_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            pattern_len_reg  <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[4:0];
                default:          ;   // unmapped index, write dropped
            endcase
        end
    end

    kmp_match_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_in      (text_in),
        .pattern_low  (pattern_low_reg),
        .pattern_high (pattern_high_reg),
        .pattern_len  (pattern_len_reg),
        .cfg_clear    (cfg_clear),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res)
    );

    // the core may finish a byte when the slot is empty or being drained
    assign out_free = !out_valid_reg || result_out.ready;

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= res;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.match_here  = out_data_reg.match_here;
    assign result_out.match_start = out_data_reg.match_start;
    assign result_out.match_count = out_data_reg.match_count;
    assign result_out.first_found = out_data_reg.first_found;
    assign result_out.first_start = out_data_reg.first_start;
    assign result_out.end_of_text = out_data_reg.end_of_text;

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for the KMP stream matcher
// Drives text byte requests and pattern configuration writes, predicts every
// result from a behavioral matcher kept in step with the accepted requests,
// and checks each result request field by field under varied back-pressure.
// ============================================================================
module tb_top;
    import kmp_pkg::*;

    // Text length limit matches the block's default.
    localparam int unsigned TEXT_LIMIT  = 1048576;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned PRINT_LIMIT = 100;
    localparam int unsigned TAIL_CYCLES = 50;

    // Index 3 maps to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kmp_text_if   text_ch ();
    kmp_result_if res_ch ();

    kmp_stream_matcher #(
        .MAX_PATTERN(16),
        .MAX_TEXT   (TEXT_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_ch),
        .result_out(res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Matcher model state: configuration copy, link table, text progress
    // ------------------------------------------------------------------
    logic [63:0] cfg_pattern_lo;
    logic [63:0] cfg_pattern_hi;
    logic [4:0]  cfg_length;
    logic [4:0]  link_tbl [0:16];
    bit          links_built;
    int unsigned run_len;
    int unsigned text_pos;
    int unsigned hits_so_far;
    bit          first_hit;
    int unsigned first_at;

    result_t     pending_results[$];
    int unsigned error_count;
    int unsigned result_number;
    int unsigned cycle_count;
    int unsigned gap_pct;
    int unsigned stall_pct;

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake: the run is cut off well past the
    // slowest legal completion.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] pattern_byte(input int unsigned k);
        logic [127:0] both;
        both = {cfg_pattern_hi, cfg_pattern_lo};
        return both[(k % 16) * 8 +: 8];
    endfunction

    // Length field as the matcher uses it: 0 acts as 1, above 16 as 16.
    function automatic int unsigned clamp_length(input logic [4:0] field);
        if (field == 5'd0)
            return 1;
        if (field > 5'd16)
            return 16;
        return 32'(field);
    endfunction

    function automatic void build_link_table();
        int unsigned n;
        int unsigned k;
        n = clamp_length(cfg_length);
        k = 0;
        link_tbl[0] = '0;
        link_tbl[1] = '0;
        for (int unsigned i = 1; i < n; i++)
        begin
            while (k > 0 && pattern_byte(i) != pattern_byte(k))
                k = 32'(link_tbl[k]);
            if (pattern_byte(i) == pattern_byte(k))
                k++;
            link_tbl[i + 1] = k[4:0];
        end
        links_built = 1'b1;
    endfunction

    function automatic void clear_text_state();
        run_len     = 0;
        text_pos    = 0;
        hits_so_far = 0;
        first_hit   = 1'b0;
        first_at    = 0;
    endfunction

    // A write to a mapped register restarts the text and forces a rebuild.
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PATTERN_LOW:  cfg_pattern_lo = data;
            REG_PATTERN_HIGH: cfg_pattern_hi = data;
            REG_PATTERN_LEN:  cfg_length     = data[4:0];
            default:          return;
        endcase
        links_built = 1'b0;
        clear_text_state();
    endfunction

    // Advance the matcher by one text byte and return the result it owes.
    function automatic result_t match_text_byte(input logic [7:0] c, input logic last);
        result_t     r;
        int unsigned n;
        int unsigned j;
        int unsigned pos;
        int unsigned start;
        bit          hit;
        if (!links_built)
            build_link_table();
        n   = clamp_length(cfg_length);
        pos = (text_pos > TEXT_LIMIT - 1) ? TEXT_LIMIT - 1 : text_pos;
        j   = run_len;
        if (j >= n)
            j = 0;
        while (j > 0 && c != pattern_byte(j))
            j = 32'(link_tbl[j]);
        if (c == pattern_byte(j))
            j++;
        hit   = 1'b0;
        start = 0;
        if (j == n)
        begin
            hit   = 1'b1;
            start = pos + 1 - n;
            if (start > IDX_MAX)
                start = IDX_MAX;
            if (hits_so_far < TEXT_LIMIT && hits_so_far < CNT_MAX)
                hits_so_far++;
            if (!first_hit)
            begin
                first_hit = 1'b1;
                first_at  = start;
            end
            // resume from the longest border so overlaps are counted
            j = 32'(link_tbl[n]);
        end
        run_len = j;
        if (text_pos < TEXT_LIMIT)
            text_pos++;
        r.match_here  = hit;
        r.match_start = start[IDX_W-1:0];
        r.match_count = hits_so_far[CNT_W-1:0];
        r.first_found = first_hit;
        r.first_start = first_hit ? first_at[IDX_W-1:0] : '0;
        r.end_of_text = last;
        if (last)
            clear_text_state();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and field-by-field checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d with no request pending", result_number));
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.match_here !== want.match_here)
                    report_mismatch($sformatf("result %0d match_here %b want %b",
                        result_number, res_ch.match_here, want.match_here));
                if (res_ch.match_start !== want.match_start)
                    report_mismatch($sformatf("result %0d match_start %0d want %0d",
                        result_number, res_ch.match_start, want.match_start));
                if (res_ch.match_count !== want.match_count)
                    report_mismatch($sformatf("result %0d match_count %0d want %0d",
                        result_number, res_ch.match_count, want.match_count));
                if (res_ch.first_found !== want.first_found)
                    report_mismatch($sformatf("result %0d first_found %b want %b",
                        result_number, res_ch.first_found, want.first_found));
                if (res_ch.first_start !== want.first_start)
                    report_mismatch($sformatf("result %0d first_start %0d want %0d",
                        result_number, res_ch.first_start, want.first_start));
                if (res_ch.end_of_text !== want.end_of_text)
                    report_mismatch($sformatf("result %0d end_of_text %b want %b",
                        result_number, res_ch.end_of_text, want.end_of_text));
            end
            result_number++;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Holds valid high across back-to-back requests; random gaps go in
    // front of the request, never between a drop and a raise of valid.
    task automatic send_text_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            text_ch.valid     <= 1'b0;
            text_ch.text_byte <= 8'($urandom_range(255));
            text_ch.last_byte <= 1'($urandom_range(1));
            @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.last_byte <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        pending_results.push_back(match_text_byte(b, last));
    endtask

    // Stop requesting and let every owed result come back.
    task automatic drain_requests();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called with the matcher idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_register(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [63:0] len_word);
        write_register(REG_PATTERN_LOW, lo);
        write_register(REG_PATTERN_HIGH, hi);
        write_register(REG_PATTERN_LEN, len_word);
    endtask

    // Random pattern drawn mostly from a two-byte alphabet so that borders
    // and overlaps are common; short lengths dominate.
    task automatic load_random_pattern();
        int unsigned  sel;
        logic [4:0]   len_field;
        logic [7:0]   sym_a;
        logic [7:0]   sym_b;
        logic [127:0] both;
        logic [63:0]  len_word;
        bit           scrambled;
        sel = $urandom_range(9);
        if (sel == 0)
            len_field = 5'($urandom_range(31));
        else if (sel == 1)
            len_field = 5'd16;
        else
            len_field = 5'($urandom_range(1, 6));
        sym_a     = 8'($urandom_range(255));
        sym_b     = 8'($urandom_range(255));
        scrambled = ($urandom_range(4) == 0);
        for (int k = 0; k < 16; k++)
        begin
            if (k < clamp_length(len_field) && !scrambled)
                both[k * 8 +: 8] = $urandom_range(1) ? sym_a : sym_b;
            else
                both[k * 8 +: 8] = 8'($urandom_range(255));
        end
        len_word      = {$urandom, $urandom};
        len_word[4:0] = len_field;
        if ($urandom_range(5) == 0)
            write_register(REG_PATTERN_LEN, len_word);
        else
            load_pattern(both[63:0], both[127:64], len_word);
        if ($urandom_range(9) == 0)
            write_register(REG_UNMAPPED, {$urandom, $urandom});
    endtask

    // Text built from whole pattern copies, prefixes and pattern bytes,
    // with some fully random noise bytes.
    task automatic send_random_text(input int unsigned target, inout int unsigned sent);
        logic [7:0]  text_q[$];
        int unsigned n;
        int unsigned pick;
        int unsigned plen;
        n = clamp_length(cfg_length);
        while (text_q.size() < target)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                for (int unsigned k = 0; k < n; k++)
                    text_q.push_back(pattern_byte(k));
            end
            else if (pick < 45)
            begin
                plen = $urandom_range(1, n);
                for (int unsigned k = 0; k < plen; k++)
                    text_q.push_back(pattern_byte(k));
            end
            else if (pick < 90)
                text_q.push_back(pattern_byte($urandom_range(0, n - 1)));
            else
                text_q.push_back(8'($urandom_range(255)));
        end
        for (int k = 0; k < text_q.size(); k++)
        begin
            // now and then poke a register in the middle of a text
            if (k != 0 && $urandom_range(199) == 0)
            begin
                drain_requests();
                if ($urandom_range(1) == 0)
                    write_register(REG_UNMAPPED, {$urandom, $urandom});
                else
                    write_register(CFG_IDX_W'($urandom_range(2)), {$urandom, $urandom});
            end
            send_text_byte(text_q[k], k == text_q.size() - 1);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset pattern is a single zero byte.
    task automatic test_reset_pattern();
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b1);
        drain_requests();
    endtask

    // "aba" in "ababa": two overlapping occurrences.
    task automatic test_overlapping_matches();
        load_pattern(64'h0000_0000_0061_6261, 64'h0, 64'd3);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h61, 1'b1);
        drain_requests();
    endtask

    // Length field of 31 acts as the full 16 bytes; periodic pattern gives
    // a border of 14 bytes.
    task automatic test_full_length();
        load_pattern(64'hFF00_FF00_FF00_FF00, 64'hFF00_FF00_FF00_FF00, '1);
        for (int k = 0; k < 17; k++)
            send_text_byte((k % 2) ? 8'hFF : 8'h00, k == 16);
        drain_requests();
    endtask

    // Length 0 acts as 1; a write to the unmapped index must not restart
    // the text in progress.
    task automatic test_zero_length_and_unmapped();
        write_register(REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
        send_text_byte(8'h61, 1'b0);
        drain_requests();
        write_register(REG_UNMAPPED, '1);
        send_text_byte(8'h61, 1'b1);
        drain_requests();
    endtask

    // Long texts dense with hits: counts and first start over many bytes.
    task automatic test_long_text();
        gap_pct   = 19;
        stall_pct = 19;
        load_pattern(64'h0000_0000_0000_005A, 64'h0, 64'd1);
        for (int k = 0; k < 300; k++)
            send_text_byte(($urandom_range(99) < 97) ? 8'h5A : 8'($urandom_range(255)),
                           k == 299);
        drain_requests();
        load_pattern(64'h0000_0000_6261_6261, 64'h0, 64'd4);
        for (int k = 0; k < 280; k++)
            send_text_byte(($urandom_range(99) < 98) ? ((k % 2) ? 8'h62 : 8'h61)
                                                      : 8'($urandom_range(255)), k == 279);
        drain_requests();
    endtask

    task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                       input int unsigned budget);
        int unsigned sent;
        gap_pct   = gap;
        stall_pct = stall;
        sent      = 0;
        while (sent < budget)
        begin
            if (sent == 0 || $urandom_range(2) == 0)
            begin
                drain_requests();
                load_random_pattern();
            end
            send_random_text($urandom_range(1, 40), sent);
        end
        drain_requests();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= '0;
        text_ch.last_byte <= 1'b0;
        gap_pct           = 0;
        stall_pct         = 0;
        error_count       = 0;
        result_number     = 0;
        cfg_pattern_lo    = '0;
        cfg_pattern_hi    = '0;
        cfg_length        = 5'd1;
        for (int k = 0; k < 17; k++)
            link_tbl[k] = '0;
        links_built = 1'b0;
        clear_text_state();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pattern();
        test_overlapping_matches();
        test_full_length();
        test_zero_length_and_unmapped();
        test_long_text();
        test_random_traffic(0, 0, 300);
        test_random_traffic(64, 0, 300);
        test_random_traffic(0, 64, 300);
        test_random_traffic(19, 19, 300);

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/kmp_pkg.sv
src/kmp_if.sv
src/kmp_link_table.sv
src/kmp_match_core.sv
src/kmp_stream_matcher.sv
sim/tb_top.sv
